// ===== hw/rtl/hcbp_pkg.sv =====
// Shared types, constants and helpers for the Huffman code bit packer.
package hcbp_pkg;

  localparam int MaxCodeLen  = 16;
  localparam int SymbolCount = 256;

  localparam int AddrW    = $clog2(SymbolCount);
  localparam int LenW     = $clog2(MaxCodeLen + 1);
  localparam int PendW    = 7;
  localparam int PcntW    = 3;
  localparam int AccW     = PendW + MaxCodeLen;
  localparam int SumW     = $clog2(AccW + 1);
  localparam int MaxBytes = AccW / 8;
  localparam int EcntW    = $clog2(MaxBytes + 1);

  typedef enum logic [1:0] {
    CmdLoad   = 2'd0,
    CmdEncode = 2'd1,
    CmdFlush  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  symbol;
    logic [15:0] code_value;
    logic [4:0]  code_len;
  } hcbp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } hcbp_out_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [AddrW-1:0]      addr;
    logic [LenW-1:0]       len;
    logic [MaxCodeLen-1:0] pat;
  } tbl_req_t;

  typedef struct packed {
    logic [LenW-1:0]       len;
    logic [MaxCodeLen-1:0] pat;
  } tbl_rsp_t;

  typedef struct packed {
    logic valid;
    logic flush;
  } s1_cmd_t;

  function automatic logic [MaxCodeLen-1:0] mask_pattern(logic [15:0] val,
                                                         logic [LenW-1:0] len);
    logic [MaxCodeLen-1:0] r;
    logic [31:0]           v;
    r = '0;
    v = 32'(val);
    for (int i = 0; i < MaxCodeLen; i++) begin
      if (i < int'(len)) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/huffman_code_bit_packer_top.sv =====
// Huffman code bit packer top level: command decode, code table and packing stage.
// An input transfer is taken every cycle unless the packing stage holds an item that
// cannot hand its bytes to the output buffer. Loads write the code table at the edge
// that takes them; an encode reads the table at that same edge and is packed in the
// next cycle; its bytes enter the registered output byte buffer when the packing stage
// advances. Bytes leave one per cycle while the output is not stalled: after an item
// yields two bytes, the next item waits in the packing stage until the first of them
// has left, so the output byte buffer limits the rate of two-byte items.
// The table resets to all lengths zero through per-entry valid bits, with no clearing
// pass. A flush emits the partial byte padded with zero bits.
module huffman_code_bit_packer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hcbp_pkg::hcbp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hcbp_pkg::hcbp_out_t out_data_o
);

  hcbp_pkg::tbl_req_t tbl_req;
  hcbp_pkg::tbl_rsp_t tbl_rsp;
  hcbp_pkg::s1_cmd_t  s1_cmd;
  hcbp_pkg::cmd_e     cmd;
  logic               in_fire, sym_ok, busy;
  logic [4:0]         len_sat;

  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !busy;
  assign cmd        = hcbp_pkg::cmd_e'(in_data_i.cmd);
  assign sym_ok     = ({1'b0, in_data_i.symbol} < 9'(hcbp_pkg::SymbolCount));
  assign len_sat    = (in_data_i.code_len > 5'(hcbp_pkg::MaxCodeLen)) ?
                      5'(hcbp_pkg::MaxCodeLen) : in_data_i.code_len;

  always_comb begin
    tbl_req.we   = 1'b0;
    tbl_req.re   = 1'b0;
    tbl_req.addr = in_data_i.symbol[hcbp_pkg::AddrW-1:0];
    tbl_req.len  = hcbp_pkg::LenW'(len_sat);
    tbl_req.pat  = hcbp_pkg::mask_pattern(in_data_i.code_value, tbl_req.len);
    s1_cmd       = '0;
    unique case (cmd)
      hcbp_pkg::CmdLoad: begin
        tbl_req.we = in_fire && sym_ok;
      end
      hcbp_pkg::CmdEncode: begin
        tbl_req.re   = in_fire && sym_ok;
        s1_cmd.valid = in_fire && sym_ok;
      end
      hcbp_pkg::CmdFlush: begin
        s1_cmd.valid = in_fire;
        s1_cmd.flush = 1'b1;
      end
      hcbp_pkg::CmdNone: begin
      end
      default: begin
      end
    endcase
  end

  hcbp_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  hcbp_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_cmd_i    (s1_cmd),
    .rsp_i       (tbl_rsp),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/hcbp_table.sv =====
// Code table: synchronous memory of length and pattern, with per-entry valid bits.
module hcbp_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcbp_pkg::tbl_req_t req_i,
  output hcbp_pkg::tbl_rsp_t rsp_o
);

  localparam int WordW = hcbp_pkg::LenW + hcbp_pkg::MaxCodeLen;

  logic [WordW-1:0]                 mem [hcbp_pkg::SymbolCount];
  logic [hcbp_pkg::SymbolCount-1:0] vld_q;
  logic [WordW-1:0]                 rd_q;
  logic                             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= {req_i.len, req_i.pat};
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.addr];
      end
    end
  end

  assign rsp_o.len = rd_vld_q ? rd_q[WordW-1 -: hcbp_pkg::LenW] : '0;
  assign rsp_o.pat = rd_q[hcbp_pkg::MaxCodeLen-1:0];

endmodule

// ===== hw/rtl/hcbp_pack.sv =====
// Packing stage: merges code bits with pending bits and drains bytes one per cycle while the output is not stalled.
module hcbp_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcbp_pkg::s1_cmd_t   s1_cmd_i,
  input  hcbp_pkg::tbl_rsp_t  rsp_i,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hcbp_pkg::hcbp_out_t out_data_o
);

  logic                              s1_valid_q, s1_flush_q;
  logic [hcbp_pkg::PendW-1:0]        pend_q, pend_d;
  logic [hcbp_pkg::PcntW-1:0]        pcnt_q, pcnt_d;
  logic [hcbp_pkg::MaxBytes-1:0][7:0] ebuf_q, ebuf_d, grp;
  logic [hcbp_pkg::EcntW-1:0]        ecnt_q, ecnt_d, ngrp;
  logic [hcbp_pkg::AccW-1:0]         acc;
  logic [hcbp_pkg::SumW-1:0]         cnt, sh;
  logic                              out_fire, adv;

  assign out_valid_o = (ecnt_q != '0);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign adv         = s1_valid_q && ((ecnt_q == '0) ||
                       ((ecnt_q == hcbp_pkg::EcntW'(1)) && out_fire));
  assign busy_o      = s1_valid_q && !adv;

  assign out_data_o.out_byte    = ebuf_q[0];
  assign out_data_o.last_of_run = (ecnt_q == hcbp_pkg::EcntW'(1));

  always_comb begin
    acc    = (hcbp_pkg::AccW'(pend_q) << rsp_i.len) | hcbp_pkg::AccW'(rsp_i.pat);
    cnt    = hcbp_pkg::SumW'(pcnt_q) + hcbp_pkg::SumW'(rsp_i.len);
    grp    = '0;
    ngrp   = '0;
    pend_d = pend_q;
    pcnt_d = pcnt_q;
    sh     = '0;
    if (s1_flush_q) begin
      if (pcnt_q != '0) begin
        grp[0] = 8'({1'b0, pend_q} << (4'd8 - {1'b0, pcnt_q}));
        ngrp   = hcbp_pkg::EcntW'(1);
        pend_d = '0;
        pcnt_d = '0;
      end
    end else if (rsp_i.len != '0) begin
      for (int k = 0; k < hcbp_pkg::MaxBytes; k++) begin
        sh     = cnt - hcbp_pkg::SumW'(8 * (k + 1));
        grp[k] = 8'(acc >> sh);
      end
      ngrp   = hcbp_pkg::EcntW'(cnt >> 3);
      pcnt_d = cnt[hcbp_pkg::PcntW-1:0];
      pend_d = hcbp_pkg::PendW'(acc) & ~({hcbp_pkg::PendW{1'b1}} << pcnt_d);
    end
  end

  always_comb begin
    ebuf_d = ebuf_q;
    ecnt_d = ecnt_q;
    if (adv && ngrp != '0) begin
      ebuf_d = grp;
      ecnt_d = ngrp;
    end else if (out_fire) begin
      for (int k = 0; k < hcbp_pkg::MaxBytes; k++) begin
        if (k + 1 < hcbp_pkg::MaxBytes) begin
          ebuf_d[k] = ebuf_q[k+1];
        end else begin
          ebuf_d[k] = '0;
        end
      end
      ecnt_d = ecnt_q - hcbp_pkg::EcntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    ebuf_q <= ebuf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
      pend_q     <= '0;
      pcnt_q     <= '0;
      ecnt_q     <= '0;
    end else begin
      if (s1_cmd_i.valid) begin
        s1_valid_q <= 1'b1;
        s1_flush_q <= s1_cmd_i.flush;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        pend_q <= pend_d;
        pcnt_q <= pcnt_d;
      end
      ecnt_q <= ecnt_d;
    end
  end

endmodule

// ===== hw/rtl/hcbp_checker.sv =====
// Port-level checker for the Huffman code bit packer, bound to the top level.
module hcbp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hcbp_pkg::hcbp_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transfer changed");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("byte run broken before its last byte");

  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output pending");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("activity during reset");

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_hcbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== verif/tb_huffman_code_bit_packer_top.sv =====
// Testbench for the Huffman code bit packer: directed and random transfers checked by a predictor.
module tb_huffman_code_bit_packer_top;

  typedef struct {
    hcbp_pkg::hcbp_in_t item;
    int                 gap;
  } send_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  hcbp_pkg::hcbp_in_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  hcbp_pkg::hcbp_out_t out_data_o;

  send_t               send_q[$];
  send_t               send_head;
  hcbp_pkg::hcbp_out_t bytes_due[$];

  logic [4:0]  code_len_tbl[hcbp_pkg::SymbolCount];
  logic [15:0] code_pat_tbl[hcbp_pkg::SymbolCount];
  logic [6:0]  carry_bits;
  int          carry_cnt;

  int errors = 0;
  int gap_cnt;
  int stall_left;
  int stall_next;
  bit send_calm = 1'b1;
  bit recv_calm;
  bit jam_go = 1'b0;
  bit jam_taken;
  bit live[hcbp_pkg::SymbolCount];

  huffman_code_bit_packer_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic pack_expected(hcbp_pkg::hcbp_in_t it);
    logic [31:0]         acc;
    int                  clen;
    int                  cnt;
    hcbp_pkg::hcbp_out_t r;
    case (hcbp_pkg::cmd_e'(it.cmd))
      hcbp_pkg::CmdLoad: begin
        clen = (it.code_len > hcbp_pkg::MaxCodeLen) ? hcbp_pkg::MaxCodeLen
                                                    : int'(it.code_len);
        code_len_tbl[it.symbol] = 5'(clen);
        code_pat_tbl[it.symbol] = it.code_value & 16'((32'd1 << clen) - 1);
      end
      hcbp_pkg::CmdEncode: begin
        clen = code_len_tbl[it.symbol];
        if (clen != 0) begin
          acc = (32'(carry_bits) << clen) | 32'(code_pat_tbl[it.symbol]);
          cnt = carry_cnt + clen;
          while (cnt >= 8) begin
            r.out_byte = 8'(acc >> (cnt - 8));
            cnt -= 8;
            r.last_of_run = (cnt < 8);
            bytes_due.push_back(r);
          end
          carry_cnt  = cnt;
          carry_bits = 7'(acc & ((32'd1 << cnt) - 1));
        end
      end
      hcbp_pkg::CmdFlush: begin
        if (carry_cnt != 0) begin
          r.out_byte = 8'({1'b0, carry_bits} << (8 - carry_cnt));
          r.last_of_run = 1'b1;
          bytes_due.push_back(r);
          carry_bits = '0;
          carry_cnt  = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_byte(hcbp_pkg::hcbp_out_t got);
    hcbp_pkg::hcbp_out_t want;
    if (bytes_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected transfer, byte %h last %b", $time, got.out_byte,
               got.last_of_run);
      return;
    end
    want = bytes_due.pop_front();
    if (got.out_byte !== want.out_byte) begin
      errors++;
      $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
    end
    if (got.last_of_run !== want.last_of_run) begin
      errors++;
      $display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run,
               got.last_of_run);
    end
  endtask

  task automatic offer(hcbp_pkg::cmd_e c, int sym, int val, int len);
    send_t s;
    s.item.cmd        = c;
    s.item.symbol     = 8'(sym);
    s.item.code_value = 16'(val);
    s.item.code_len   = 5'(len);
    s.gap             = send_calm ? 0 : $urandom_range(0, 19);
    if (c == hcbp_pkg::CmdLoad) begin
      live[8'(sym)] = (len != 0);
    end
    send_q.push_back(s);
  endtask

  task automatic drain();
    while (send_q.size() != 0 || in_valid_i || bytes_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // sender: each item waits its own gap, valid held while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_cnt    <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pack_expected(in_data_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (gap_cnt < send_q[0].gap) begin
          in_valid_i <= 1'b0;
          gap_cnt    <= gap_cnt + 1;
        end else begin
          send_head  = send_q.pop_front();
          in_valid_i <= 1'b1;
          in_data_i  <= send_head.item;
          gap_cnt    <= 0;
        end
      end
    end
  end

  // receiver: random stall after each transfer, one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      jam_taken   <= 1'b0;
      recv_calm   <= 1'b0;
    end else begin
      stall_next = stall_left;
      if (out_valid_o && !out_stall_i) begin
        check_byte(out_data_o);
        stall_next = recv_calm ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 24) == 0) begin
          recv_calm <= !recv_calm;
        end
      end
      if (jam_go && !jam_taken) begin
        stall_next = 200;
        jam_taken  <= 1'b1;
      end
      if (stall_next > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_next - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= 0;
      end
    end
  end

  initial begin
    int n;
    int pick;
    int sym;
    int len;
    for (int i = 0; i < hcbp_pkg::SymbolCount; i++) begin
      code_len_tbl[i] = '0;
      code_pat_tbl[i] = '0;
      live[i]         = 1'b0;
    end
    carry_bits = '0;
    carry_cnt  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    offer(hcbp_pkg::CmdEncode, 5, 16'h1234, 9);     // never loaded
    offer(hcbp_pkg::CmdFlush, 0, 0, 0);             // nothing pending
    offer(hcbp_pkg::CmdNone, 8'hff, 16'hffff, 31);
    offer(hcbp_pkg::CmdLoad, 0, 16'hffff, 16);
    offer(hcbp_pkg::CmdLoad, 255, 16'ha5c3, 31);    // length saturates
    offer(hcbp_pkg::CmdLoad, 1, 16'hfffe, 1);       // high pattern bits dropped
    offer(hcbp_pkg::CmdLoad, 2, 16'h0055, 7);
    offer(hcbp_pkg::CmdLoad, 3, 16'h1234, 0);
    offer(hcbp_pkg::CmdLoad, 4, 16'h0005, 3);
    offer(hcbp_pkg::CmdLoad, 6, 16'h0000, 16);
    offer(hcbp_pkg::CmdEncode, 0, 0, 0);
    offer(hcbp_pkg::CmdEncode, 1, 16'hffff, 31);
    offer(hcbp_pkg::CmdEncode, 255, 0, 0);
    offer(hcbp_pkg::CmdEncode, 2, 0, 0);
    offer(hcbp_pkg::CmdEncode, 3, 0, 0);            // zero length
    offer(hcbp_pkg::CmdEncode, 1, 0, 0);
    offer(hcbp_pkg::CmdEncode, 4, 0, 0);
    offer(hcbp_pkg::CmdFlush, 8'haa, 16'h5555, 21);
    offer(hcbp_pkg::CmdFlush, 0, 0, 0);
    offer(hcbp_pkg::CmdEncode, 2, 0, 0);            // seven bits pending
    offer(hcbp_pkg::CmdEncode, 255, 0, 0);          // fullest accumulator
    offer(hcbp_pkg::CmdEncode, 6, 0, 0);
    offer(hcbp_pkg::CmdFlush, 0, 0, 0);
    drain();

    jam_go    = 1'b1;
    send_calm = 1'b1;
    n         = 0;
    for (int k = 0; n < 250; k++) begin
      if (k % 30 == 29) begin
        send_calm = ($urandom_range(0, 2) == 0);
      end
      if (k == 140) begin
        drain();
      end
      pick = $urandom_range(0, 99);
      sym  = $urandom_range(0, 255);
      if (k < 10 || pick < 15) begin
        len = (k >= 10 && $urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 16);
        offer(hcbp_pkg::CmdLoad, sym, $urandom_range(0, 65535), len);
        n++;
      end else if (pick < 87) begin
        if ($urandom_range(0, 9) != 0) begin
          while (!live[sym]) begin
            sym = $urandom_range(0, 255);
          end
        end
        if (live[sym]) begin
          n++;
        end
        offer(hcbp_pkg::CmdEncode, sym, $urandom_range(0, 65535), $urandom_range(0, 31));
      end else if (pick < 96) begin
        offer(hcbp_pkg::CmdFlush, sym, $urandom_range(0, 65535), $urandom_range(0, 31));
        n++;
      end else begin
        offer(hcbp_pkg::CmdNone, sym, $urandom_range(0, 65535), $urandom_range(0, 31));
      end
    end
    drain();
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("tb: failure");
    $finish;
  end

endmodule
